FILE: src/pcrc_pkg.sv
package pcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [1:0] PH_ECHO = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] word;
    } res_t;

    // msb-first byte update, polynomial 0x1021
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/pcrc_in_if.sv
interface pcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: src/pcrc_out_if.sv
interface pcrc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: src/pcrc_state.sv
module pcrc_state (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [7:0]      data,
    input  logic            last,
    output pcrc_pkg::res_t  res
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic [1:0]  cnt_eff;
    logic [15:0] crc_fed;
    logic [15:0] base;
    logic [7:0]  prev;
    logic [15:0] word;

    assign cnt_eff = cnt_reg[1] ? 2'd2 : cnt_reg;
    assign crc_fed = pcrc_pkg::crc16_feed(crc_reg, held0_reg);
    assign base    = (cnt_eff == 2'd2) ? crc_fed : crc_reg;
    assign prev    = (cnt_eff == 2'd2) ? held1_reg : held0_reg;
    assign word    = (cnt_eff == 2'd0) ? 16'h0000 : (base ^ {prev, data});

    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_next   = cnt_reg;
        if (en)
        begin
            if (last)
            begin
                // end of packet clears everything
                crc_next   = pcrc_pkg::CRC_INIT;
                held0_next = 8'h00;
                held1_next = 8'h00;
                cnt_next   = 2'd0;
            end
            else if (cnt_eff == 2'd2)
            begin
                crc_next   = crc_fed;
                held0_next = held1_reg;
                held1_next = data;
                cnt_next   = 2'd2;
            end
            else if (cnt_eff == 2'd1)
            begin
                held1_next = data;
                cnt_next   = 2'd2;
            end
            else
            begin
                held0_next = data;
                cnt_next   = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= pcrc_pkg::CRC_INIT;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign res.data = data;
    assign res.last = last;
    assign res.word = word;

endmodule

FILE: src/pcrc_emit.sv
module pcrc_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pcrc_pkg::res_t    res,
    output logic              free,
    pcrc_out_if.source        pkt_out
);

    logic            valid_reg, valid_next;
    logic [1:0]      phase_reg, phase_next;
    pcrc_pkg::res_t  res_reg;

    logic fire;
    logic done;

    assign fire = valid_reg && pkt_out.ready;
    assign done = fire && (!res_reg.last || (phase_reg == pcrc_pkg::PH_HI));
    assign free = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = pcrc_pkg::PH_ECHO;
        end
        else if (done)
        begin
            valid_next = 1'b0;
            phase_next = pcrc_pkg::PH_ECHO;
        end
        else if (fire)
        begin
            case (phase_reg)
                pcrc_pkg::PH_ECHO: phase_next = pcrc_pkg::PH_LO;
                pcrc_pkg::PH_LO:   phase_next = pcrc_pkg::PH_HI;
                default:           phase_next = pcrc_pkg::PH_ECHO;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= pcrc_pkg::PH_ECHO;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    always_comb
    begin
        case (phase_reg)
            pcrc_pkg::PH_ECHO:
            begin
                pkt_out.out_byte = res_reg.data;
                pkt_out.out_last = 1'b0;
            end
            pcrc_pkg::PH_LO:
            begin
                pkt_out.out_byte = res_reg.word[7:0];
                pkt_out.out_last = 1'b0;
            end
            default:
            begin
                pkt_out.out_byte = res_reg.word[15:8];
                pkt_out.out_last = 1'b1;
            end
        endcase
    end

    assign pkt_out.valid = valid_reg;

endmodule

FILE: src/payload_crc16_tail_xor.sv
// an accepted byte passes the s1 register, then the emit result register
// throughput: one byte per cycle while pkt_out is ready; a last byte holds
// the single result register for its echo, crc low and crc high bytes
// reset: rst_n clears crc, held bytes and all valid flags asynchronously
module payload_crc16_tail_xor (
    input  logic        clk,
    input  logic        rst_n,
    pcrc_in_if.sink     pkt_in,
    pcrc_out_if.source  pkt_out
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    logic           accept;
    logic           advance;
    logic           emit_free;
    pcrc_pkg::res_t res;

    assign advance      = s1_valid_reg && emit_free;
    assign pkt_in.ready = !s1_valid_reg || advance;
    assign accept       = pkt_in.valid && pkt_in.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= pkt_in.in_byte;
            s1_last_reg <= pkt_in.in_last;
        end
    end

    pcrc_state u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .data  (s1_byte_reg),
        .last  (s1_last_reg),
        .res   (res)
    );

    pcrc_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .res     (res),
        .free    (emit_free),
        .pkt_out (pkt_out)
    );

endmodule
